/* sv/fda_pkg.sv */
// Shared types, constants and arithmetic helpers for the fractional-delay allpass.
package fda_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int CFG_W     = 21;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [GAIN_W-1:0]   gain_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
    typedef logic [CFG_W-1:0]           cfg_data_t;

    // Register indexes on the configuration port
    localparam cfg_idx_t REG_FEEDBACK_GAIN = 2'd0;
    localparam cfg_idx_t REG_DELAY_LENGTH  = 2'd1;

    localparam gain_t GAIN_RESET        = 16'sd3277;
    localparam int    DELAY_RESET       = 256;
    localparam int    GAIN_ROUND        = 16384;
    localparam int    GAIN_FRAC_BITS    = 15;

    // Saturate an 18-bit signed value to a 16-bit sample
    function automatic sample_t sat16(input logic signed [SAMPLE_W+1:0] v);
        sample_t r;
        if (v > 18'sd32767)
            r = 16'sd32767;
        else if (v < -18'sd32768)
            r = -16'sd32768;
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

    // (gain * x + 2^14) >> 15, floor shift
    function automatic logic signed [SAMPLE_W:0] gain_mul(input gain_t g, input sample_t x);
        logic signed [GAIN_W+SAMPLE_W-1:0] p;
        logic signed [GAIN_W+SAMPLE_W-1:0] pr;
        p  = g * x;
        pr = p + 32'(GAIN_ROUND);
        return pr[GAIN_W+SAMPLE_W-1:GAIN_FRAC_BITS];
    endfunction

endpackage

/* sv/fda_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module fda_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/fda_cfg.sv */
// Configuration registers: allpass gain and clamped fractional delay.
module fda_cfg #(
    parameter int LINE_DEPTH          = 4096,
    parameter int DELAY_FRACTION_BITS = 8
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            cfg_we,
    input  fda_pkg::cfg_idx_t                               cfg_index,
    input  fda_pkg::cfg_data_t                              cfg_data,
    output fda_pkg::gain_t                                  feedback_gain,
    output logic [$clog2(LINE_DEPTH)+DELAY_FRACTION_BITS:0] delay_length
);
    import fda_pkg::*;

    // Delay register holds up to the full line depth in fixed point
    localparam int     DW         = $clog2(LINE_DEPTH) + DELAY_FRACTION_BITS + 1;
    localparam int     CW         = (DW > CFG_W) ? DW : CFG_W;
    localparam longint FULL_RANGE = longint'(LINE_DEPTH) << DELAY_FRACTION_BITS;
    localparam logic [CW-1:0] FULL_CW = CW'(FULL_RANGE);
    localparam longint DELAY_INIT = (FULL_RANGE < longint'(DELAY_RESET)) ?
                                    FULL_RANGE : longint'(DELAY_RESET);

    gain_t           feedback_gain_reg;
    logic [DW-1:0]   delay_length_reg;
    logic [CW-1:0]   cfg_data_ext;
    logic [CW-1:0]   delay_clamped;

    // Clamp the delay to the line depth
    assign cfg_data_ext  = CW'(cfg_data);
    assign delay_clamped = (cfg_data_ext > FULL_CW) ? FULL_CW : cfg_data_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feedback_gain_reg <= GAIN_RESET;
            delay_length_reg  <= DW'(DELAY_INIT);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FEEDBACK_GAIN: feedback_gain_reg <= gain_t'(cfg_data[GAIN_W-1:0]);
                REG_DELAY_LENGTH:  delay_length_reg  <= delay_clamped[DW-1:0];
                default:           ; // drop writes to unknown registers
            endcase
        end
    end

    assign feedback_gain = feedback_gain_reg;
    assign delay_length  = delay_length_reg;

endmodule

/* sv/fda_core.sv */
// Sequencer and datapath: pointer update, interpolated read, allpass arithmetic.
module fda_core #(
    parameter int LINE_DEPTH          = 4096,
    parameter int DELAY_FRACTION_BITS = 8
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  fda_pkg::gain_t                                       feedback_gain,
    input  logic [$clog2(LINE_DEPTH)+DELAY_FRACTION_BITS:0]      delay_length,
    input  logic                                                 in_valid,
    output logic                                                 in_ready,
    input  fda_pkg::sample_t                                     sample_in,
    output logic                                                 out_valid,
    input  logic                                                 out_ready,
    output fda_pkg::sample_t                                     sample_out
);
    import fda_pkg::*;

    localparam int    AW         = $clog2(LINE_DEPTH);
    localparam int    FB         = DELAY_FRACTION_BITS;
    localparam int    PW         = AW + FB + 1;
    localparam int    PRW        = SAMPLE_W + FB + 2;
    localparam longint FULL_RANGE = longint'(LINE_DEPTH) << FB;
    localparam logic [PW-1:0] FULL_PW = PW'(FULL_RANGE);
    localparam logic [AW-1:0] LAST_IDX = AW'(LINE_DEPTH - 1);
    localparam logic [FB:0]   ONE      = (FB+1)'(1) << FB;
    localparam logic signed [PRW-1:0] HALF = PRW'(longint'(1) << (FB - 1));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_RD_A,
        ST_RD_B,
        ST_INTERP,
        ST_STORE,
        ST_OUT
    } state_t;

    state_t              state_reg;
    logic [AW-1:0]       wp_reg;
    logic                full_reg;
    sample_t             x_reg;
    logic [AW-1:0]       i1_reg;
    logic [AW-1:0]       i2_reg;
    logic [FB-1:0]       frac_reg;
    logic                va_reg;
    logic                vb_reg;
    logic signed [PRW-1:0] prod_a_reg;
    sample_t             delayed_reg;
    sample_t             stored_reg;
    logic                out_valid_reg;
    sample_t             sample_out_reg;

    logic [AW-1:0]       wp_next;
    logic [PW-1:0]       pos_sum;
    logic [PW-1:0]       pos_wrap;
    logic [AW-1:0]       i1_next;
    logic [AW-1:0]       i2_next;
    logic                va_next;
    logic                vb_next;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic [AW-1:0]       ram_raddr;
    sample_t             tap_a;
    sample_t             tap_b;
    logic signed [PRW-1:0] prod_a_next;
    logic signed [PRW-1:0] prod_b;
    logic signed [PRW-1:0] interp_sum;
    sample_t             delayed_next;
    sample_t             stored_next;
    sample_t             result_next;
    logic                out_valid_next;

    // Advance the circular write pointer
    assign wp_next = (wp_reg == LAST_IDX) ? '0 : wp_reg + AW'(1);

    // Read position: pointer minus delay, wrapped once into the line
    always_comb
    begin
        pos_sum  = {1'b0, wp_reg, FB'(0)} + FULL_PW - delay_length;
        pos_wrap = (pos_sum >= FULL_PW) ? pos_sum - FULL_PW : pos_sum;
        i1_next  = pos_wrap[AW+FB-1:FB];
        i2_next  = (i1_next == LAST_IDX) ? '0 : i1_next + AW'(1);
    end

    // An entry not yet written since reset reads as zero
    assign va_next = full_reg || ((i1_next != '0) && ((i1_next < wp_reg) || (wp_reg == '0)));
    assign vb_next = full_reg || ((i2_next != '0) && ((i2_next < wp_reg) || (wp_reg == '0)));

    assign ram_raddr = (state_reg == ST_RD_A) ? i1_reg : i2_reg;
    assign tap_a     = va_reg ? sample_t'(ram_rdata) : '0;
    assign tap_b     = vb_reg ? sample_t'(ram_rdata) : '0;

    always_comb
    begin
        prod_a_next  = PRW'(tap_a) * PRW'($signed({1'b0, ONE - {1'b0, frac_reg}}));
        prod_b       = PRW'(tap_b) * PRW'($signed({1'b0, {1'b0, frac_reg}}));
        interp_sum   = prod_a_reg + prod_b + HALF;
        delayed_next = interp_sum[FB+SAMPLE_W-1:FB];
        stored_next  = sat16((SAMPLE_W+2)'(gain_mul(feedback_gain, delayed_reg))
                             + (SAMPLE_W+2)'(x_reg));
        result_next  = sat16((SAMPLE_W+2)'(delayed_reg)
                             - (SAMPLE_W+2)'(gain_mul(feedback_gain, stored_reg)));
    end

    // Output register: load in the last step, hold while the receiver stalls
    assign out_valid_next = (state_reg == ST_OUT) || (out_valid_reg && !out_ready);

    fda_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (state_reg == ST_STORE),
        .waddr (wp_reg),
        .wdata (stored_next),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        x_reg     <= sample_in;
                        wp_reg    <= wp_next;
                        state_reg <= ST_ADDR;
                    end
                end
                ST_ADDR:
                begin
                    i1_reg    <= i1_next;
                    i2_reg    <= i2_next;
                    frac_reg  <= pos_wrap[FB-1:0];
                    va_reg    <= va_next;
                    vb_reg    <= vb_next;
                    state_reg <= ST_RD_A;
                end
                ST_RD_A:
                begin
                    state_reg <= ST_RD_B;
                end
                ST_RD_B:
                begin
                    prod_a_reg <= prod_a_next;
                    state_reg  <= ST_INTERP;
                end
                ST_INTERP:
                begin
                    delayed_reg <= delayed_next;
                    state_reg   <= ST_STORE;
                end
                ST_STORE:
                begin
                    stored_reg <= stored_next;
                    if (wp_reg == '0)
                    begin
                        full_reg <= 1'b1;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        sample_out_reg <= result_next;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

endmodule

/* sv/fractional_delay_allpass.sv */
// Top level of the fractional-delay Schroeder allpass section.
//
// Usage:
//   Samples enter on the in_valid/in_ready/sample_in channel and results leave
//   on out_valid/out_ready/sample_out; a transaction completes on a rising edge
//   where valid and ready are both high. Each input sample yields exactly one
//   output sample.
//   Each accepted sample passes through the sequencer: two reads through the
//   single read port of the delay-line memory, then the interpolation and two
//   gain multiplies, each behind a register, before the result is loaded into
//   the output register. A new sample is accepted only once the sequencer is
//   back in idle, so samples are processed one at a time.
//   The output register holds a finished result while the next sample is
//   accepted and processed; if the receiver stalls, the sequencer holds the
//   following result until the output register drains.
//   Reset clears the write pointer and sets the gain (about 0.1) and the delay (one
//   sample). The delay-line memory is not swept: a fill mark tracks which
//   entries have been written since reset, and unwritten entries read as
//   zero, so the block is ready straight out of reset.
//   Configuration writes (gain, delay) take effect at once; the delay is
//   clamped to the line depth. Write only while no transaction is in flight.
module fractional_delay_allpass #(
    parameter int LINE_DEPTH          = 4096,
    parameter int DELAY_FRACTION_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  fda_pkg::cfg_idx_t  cfg_index,
    input  fda_pkg::cfg_data_t cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  fda_pkg::sample_t   sample_in,
    output logic               out_valid,
    input  logic               out_ready,
    output fda_pkg::sample_t   sample_out
);
    import fda_pkg::*;

    // Delay register holds up to the full line depth in fixed point
    localparam int DW = $clog2(LINE_DEPTH) + DELAY_FRACTION_BITS + 1;

    gain_t           feedback_gain;
    logic [DW-1:0]   delay_length;

    // Gain and delay registers, written from the configuration port
    fda_cfg #(
        .LINE_DEPTH          (LINE_DEPTH),
        .DELAY_FRACTION_BITS (DELAY_FRACTION_BITS)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .feedback_gain (feedback_gain),
        .delay_length  (delay_length)
    );

    // Sequencer, arithmetic and delay-line memory
    fda_core #(
        .LINE_DEPTH          (LINE_DEPTH),
        .DELAY_FRACTION_BITS (DELAY_FRACTION_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .feedback_gain (feedback_gain),
        .delay_length  (delay_length),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_in     (sample_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sample_out    (sample_out)
    );

endmodule
